// ===== rtl/kat_pkg.sv =====
// Shared types, constants and keyframe tables of the ambient tint unit.
package kat_pkg;

    localparam int STEPS_PER_DAY_DEF = 48;
    localparam int KEY_COUNT         = 8;
    localparam int STEP_W            = 8;
    localparam int PIX_W             = 16;
    localparam int LIGHT_W           = 8;
    localparam int CHAN_COUNT        = 3;
    localparam int PROD_W            = 18;
    localparam int SCALED_W          = 14;

    localparam int CH_R = 0;
    localparam int CH_G = 1;
    localparam int CH_B = 2;

    // Reciprocal of three: (x * 683) >> 11 equals x / 3 for x below 1024.
    localparam int RECIP3       = 683;
    localparam int RECIP3_SHIFT = 11;
    localparam int SPAN4_SHIFT  = 2;

    localparam logic [SCALED_W-1:0] ROUND_HALF = SCALED_W'(127);
    localparam logic [PIX_W-1:0]    PIX_BLACK  = 16'h0000;
    localparam logic [PIX_W-1:0]    PIX_FLOOR  = 16'h0001;

    typedef logic [LIGHT_W-1:0] light_t;
    typedef light_t [CHAN_COUNT-1:0] rgb_light_t;

    // Curve segments, named after the keyframes at their two ends.
    typedef enum logic [2:0] {
        SEG_NIGHT_EARLY,
        SEG_NIGHT_DAWN,
        SEG_DAWN_DAY,
        SEG_DAY,
        SEG_DAY_DUSK,
        SEG_DUSK_NIGHT,
        SEG_NIGHT_LATE
    } seg_t;

    // Stage load enables of the curve pipeline.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } curve_en_t;

    // Keyframe steps; the last keyframe sits at the steps-per-day parameter.
    localparam logic [STEP_W-1:0] KEY_STEP [0:KEY_COUNT-2] = '{
        8'd0, 8'd9, 8'd12, 8'd15, 8'd34, 8'd38, 8'd42
    };

    // Multipliers per keyframe: night, night, dawn, day, day, dusk, night, night.
    localparam logic [LIGHT_W-1:0] KEY_LIGHT [0:KEY_COUNT-1][0:CHAN_COUNT-1] = '{
        '{8'd88,  8'd104, 8'd160},
        '{8'd88,  8'd104, 8'd160},
        '{8'd205, 8'd165, 8'd150},
        '{8'd255, 8'd255, 8'd255},
        '{8'd255, 8'd255, 8'd255},
        '{8'd245, 8'd150, 8'd105},
        '{8'd88,  8'd104, 8'd160},
        '{8'd88,  8'd104, 8'd160}
    };

endpackage

// ===== rtl/kat_curve.sv =====
// Four-stage pipeline that turns the day step into three channel multipliers.
module kat_curve #(
    parameter int STEPS_PER_DAY = kat_pkg::STEPS_PER_DAY_DEF
) (
    input  logic                              aclk,
    input  kat_pkg::curve_en_t                en,
    input  logic [kat_pkg::STEP_W-1:0]        time_step,
    output kat_pkg::rgb_light_t               light
);
    import kat_pkg::*;

    localparam int WRAPS  = 255 / STEPS_PER_DAY;
    localparam int WIDE_W = STEP_W + 3;

    logic [STEP_W-1:0]              at_reg, at_next;
    seg_t                           seg_reg, seg_next, seg3_reg;
    logic [STEP_W-1:0]              trav_reg, trav_next;
    logic signed [PROD_W-1:0]       prod_reg [CHAN_COUNT];
    logic signed [PROD_W-1:0]       prod_next [CHAN_COUNT];
    rgb_light_t                     light_reg, light_next;

    // Stage 1: reduce the step modulo the day length.
    always_comb begin
        at_next = time_step;
        for (int k = 1; k <= WRAPS; k++) begin
            if (WIDE_W'(time_step) >= WIDE_W'(k * STEPS_PER_DAY)) begin
                at_next = STEP_W'(WIDE_W'(time_step) - WIDE_W'(k * STEPS_PER_DAY));
            end
        end
    end

    // Stage 2: find the segment holding the step, and the distance travelled.
    always_comb begin
        seg_next  = SEG_NIGHT_LATE;
        trav_next = at_reg - KEY_STEP[KEY_COUNT-2];
        for (int i = KEY_COUNT - 2; i >= 1; i--) begin
            if (at_reg < KEY_STEP[i]) begin
                seg_next  = seg_t'(i - 1);
                trav_next = at_reg - KEY_STEP[i-1];
            end
        end
    end

    // Stage 3: signed delta times travelled, per channel, at full product width.
    always_comb begin
        logic signed [PROD_W-1:0] delta;
        for (int c = 0; c < CHAN_COUNT; c++) begin
            delta = $signed(PROD_W'(KEY_LIGHT[seg_reg + 3'd1][c]))
                    - $signed(PROD_W'(KEY_LIGHT[seg_reg][c]));
            prod_next[c] = delta * $signed(PROD_W'(trav_reg));
        end
    end

    // Stage 4: divide by the span, truncating toward zero, and add the start.
    always_comb begin
        logic [PROD_W-1:0]              mag;
        logic [PROD_W+RECIP3_SHIFT-1:0] recip;
        logic [LIGHT_W-1:0]             quo;
        for (int c = 0; c < CHAN_COUNT; c++) begin
            mag   = prod_reg[c][PROD_W-1] ? PROD_W'(-prod_reg[c]) : PROD_W'(prod_reg[c]);
            recip = (PROD_W+RECIP3_SHIFT)'(mag) * (PROD_W+RECIP3_SHIFT)'(RECIP3);
            unique case (seg3_reg) inside
                SEG_NIGHT_DAWN, SEG_DAWN_DAY: quo = LIGHT_W'(recip >> RECIP3_SHIFT);
                SEG_DAY_DUSK, SEG_DUSK_NIGHT: quo = LIGHT_W'(mag >> SPAN4_SHIFT);
                // Flat segments: both ends carry the same light.
                default:                      quo = '0;
            endcase
            light_next[c] = KEY_LIGHT[seg3_reg][c]
                            + (prod_reg[c][PROD_W-1] ? LIGHT_W'(-quo) : quo);
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            at_reg <= at_next;
        end
        if (en.s2) begin
            seg_reg  <= seg_next;
            trav_reg <= trav_next;
        end
        if (en.s3) begin
            prod_reg <= prod_next;
            seg3_reg <= seg_reg;
        end
        if (en.s4) begin
            light_reg <= light_next;
        end
    end

    assign light = light_reg;

endmodule

// ===== rtl/keyframed_rgb565_ambient_tint_unit.sv =====
// Top level of the keyframed RGB565 ambient tint unit.
//
// Usage: write the day step on the cfg channel (cfg_data, ready whenever out
// of reset) while no pixel is in flight. Pixels enter on s_valid/s_ready/
// s_pixel_in and leave tinted on m_valid/m_ready/m_pixel_out, one result item
// per input item, in order.
// Pipeline: six register stages; throughput is one item per cycle while the
// receiver keeps m_ready high. Four stages build the ambient multipliers from
// the day step, one forms channel times multiplier plus rounding, one divides
// by 255 and repacks.
// The multipliers travel with each item, so every item sees the step that was
// in the register when it was accepted.
// Reset (aresetn low, synchronous) empties the pipeline, sets the step to 0
// and holds s_ready and cfg_ready low.
// When the receiver stalls, each stage holds its item and bubbles close up
// behind it; s_ready drops only once every stage is full.
module keyframed_rgb565_ambient_tint_unit #(
    parameter int STEPS_PER_DAY = kat_pkg::STEPS_PER_DAY_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [kat_pkg::STEP_W-1:0]    cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [kat_pkg::PIX_W-1:0]     s_pixel_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [kat_pkg::PIX_W-1:0]     m_pixel_out
);
    import kat_pkg::*;

    localparam int STAGES     = 6;
    localparam int PIX_STAGES = 4;

    logic [STEP_W-1:0]    time_step_reg;
    logic [STAGES-1:0]    valid_reg, valid_next;
    logic [STAGES-1:0]    load;
    logic [PIX_W-1:0]     pix_reg [PIX_STAGES];
    logic [SCALED_W-1:0]  scaled_reg [CHAN_COUNT];
    logic [SCALED_W-1:0]  scaled_next [CHAN_COUNT];
    logic                 black_reg;
    logic [PIX_W-1:0]     out_reg, out_next;
    curve_en_t            curve_en;
    rgb_light_t           light;

    // Divide by 255, truncating; the rounding term is already in y.
    function automatic logic [5:0] div255(input logic [SCALED_W-1:0] y);
        logic [SCALED_W:0] t;
        t = (SCALED_W+1)'(y) + (SCALED_W+1)'(y >> 8) + (SCALED_W+1)'(1);
        return 6'(t >> 8);
    endfunction

    // A stage loads when it is empty or its successor is moving.
    always_comb begin
        load[STAGES-1] = !valid_reg[STAGES-1] || m_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            load[k] = !valid_reg[k] || load[k+1];
        end
        valid_next[0] = s_valid;
        for (int k = 1; k < STAGES; k++) begin
            valid_next[k] = valid_reg[k-1];
        end
    end

    assign s_ready   = load[0] && aresetn;
    assign cfg_ready = aresetn;

    assign curve_en = '{s1: load[0], s2: load[1], s3: load[2], s4: load[3]};

    kat_curve #(
        .STEPS_PER_DAY(STEPS_PER_DAY)
    ) u_curve (
        .aclk      (aclk),
        .en        (curve_en),
        .time_step (time_step_reg),
        .light     (light)
    );

    // Stage 5: unpack and multiply each channel, add half of 255.
    always_comb begin
        scaled_next[CH_R] = SCALED_W'(pix_reg[3][15:11]) * SCALED_W'(light[CH_R]) + ROUND_HALF;
        scaled_next[CH_G] = SCALED_W'(pix_reg[3][10:5])  * SCALED_W'(light[CH_G]) + ROUND_HALF;
        scaled_next[CH_B] = SCALED_W'(pix_reg[3][4:0])   * SCALED_W'(light[CH_B]) + ROUND_HALF;
    end

    // Stage 6: divide, repack, keep black as black and lift tinted-to-black.
    always_comb begin
        logic [5:0]       red_q;
        logic [5:0]       grn_q;
        logic [5:0]       blu_q;
        logic [PIX_W-1:0] packed_px;
        red_q     = div255(scaled_reg[CH_R]);
        grn_q     = div255(scaled_reg[CH_G]);
        blu_q     = div255(scaled_reg[CH_B]);
        packed_px = {red_q[4:0], grn_q, blu_q[4:0]};
        if (black_reg) begin
            out_next = PIX_BLACK;
        end else if (packed_px == PIX_BLACK) begin
            out_next = PIX_FLOOR;
        end else begin
            out_next = packed_px;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg <= '0;
            valid_reg     <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                time_step_reg <= cfg_data;
            end
            for (int k = 0; k < STAGES; k++) begin
                if (load[k]) begin
                    valid_reg[k] <= valid_next[k];
                end
            end
        end
    end

    // Payload: advance with the stage loads, no reset.
    always_ff @(posedge aclk) begin
        if (load[0]) begin
            pix_reg[0] <= s_pixel_in;
        end
        for (int k = 1; k < PIX_STAGES; k++) begin
            if (load[k]) begin
                pix_reg[k] <= pix_reg[k-1];
            end
        end
        if (load[4]) begin
            scaled_reg <= scaled_next;
            black_reg  <= (pix_reg[3] == PIX_BLACK);
        end
        if (load[5]) begin
            out_reg <= out_next;
        end
    end

    assign m_valid     = valid_reg[STAGES-1];
    assign m_pixel_out = out_reg;

endmodule
